>>> design/bfca_pkg.sv
// Shared types, widths and codes for the best-fit coalescing allocator.
`default_nettype none
package bfca_pkg;

  localparam int CHUNK_BYTES_DEF       = 2048;
  localparam int HEADER_BYTES_DEF      = 16;
  localparam int MAX_FREE_ENTRIES_DEF  = 32;
  localparam int MAX_ALLOC_ENTRIES_DEF = 64;
  localparam int MAX_CHUNKS_DEF        = 16;

  localparam int ADDR_W  = 15;
  localparam int SIZE_W  = 15;
  localparam int ASIZE_W = 12;
  localparam int REQ_W   = 16;
  localparam int ST_W    = 3;
  localparam int LIM_W   = 5;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [ST_W-1:0] ST_LARGE   = 3'd2;
  localparam logic [ST_W-1:0] ST_OOM     = 3'd3;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd4;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] REG_CHUNK_LIMIT = 2'd0;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic   wr;
    logic   shl;
    logic   shr;
    entry_t data;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> design/bfca_cell.sv
// One free-list cell: holds one entry and takes a neighbor's entry on a shift.
`default_nettype none
module bfca_cell (
  input  wire logic               clk,
  input  wire bfca_pkg::cell_cmd_t cmd,
  input  wire bfca_pkg::entry_t   left,
  input  wire bfca_pkg::entry_t   right,
  output bfca_pkg::entry_t        q
);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      q <= cmd.data;
    end else if (cmd.shl) begin
      q <= right;
    end else if (cmd.shr) begin
      q <= left;
    end
  end

endmodule
`default_nettype wire

>>> design/best_fit_coalescing_allocator.sv
// Top level of the best-fit free-list allocator with coalescing.
// Requests are handled one at a time. The free list lives in a row of cells kept
// in address order; an insert or removal shifts the cells past the position together. An allocate
// scans the live-allocation valid bits for a slot, walks the free list once for
// the best fit, and, when a chunk must be added, walks it again to place the
// chunk before a second fit pass. A free walks the allocation table through its
// registered read port, then places the block. A final state hands the result to
// the output register.
`default_nettype none
module best_fit_coalescing_allocator #(
  parameter int CHUNK_BYTES       = bfca_pkg::CHUNK_BYTES_DEF,
  parameter int HEADER_BYTES      = bfca_pkg::HEADER_BYTES_DEF,
  parameter int MAX_FREE_ENTRIES  = bfca_pkg::MAX_FREE_ENTRIES_DEF,
  parameter int MAX_ALLOC_ENTRIES = bfca_pkg::MAX_ALLOC_ENTRIES_DEF,
  parameter int MAX_CHUNKS        = bfca_pkg::MAX_CHUNKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // req_size[15:0], addr[30:16], zero pad
  input  wire logic [0:0]  s_tuser,   // op[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // addr_res[14:0], zero pad
  output logic [2:0]       m_tuser,   // status[2:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW  = bfca_pkg::ADDR_W;
  localparam int SW  = bfca_pkg::SIZE_W;
  localparam int ASW = bfca_pkg::ASIZE_W;
  localparam int RW  = bfca_pkg::REQ_W;
  localparam int STW = bfca_pkg::ST_W;
  localparam int LW  = bfca_pkg::LIM_W;
  localparam int PAYLOAD = CHUNK_BYTES - HEADER_BYTES;
  localparam int FI_W = (MAX_FREE_ENTRIES > 1) ? $clog2(MAX_FREE_ENTRIES) : 1;
  localparam int FC_W = $clog2(MAX_FREE_ENTRIES + 1);
  localparam int AI_W = (MAX_ALLOC_ENTRIES > 1) ? $clog2(MAX_ALLOC_ENTRIES) : 1;
  localparam int CU_W = $clog2(MAX_CHUNKS + 1);
  localparam int WW   = 18;
  localparam logic [WW-1:0] HDR = WW'(HEADER_BYTES);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SLOT  = 4'd1;
  localparam logic [3:0] S_FIT   = 4'd2;
  localparam logic [3:0] S_TAKE  = 4'd3;
  localparam logic [3:0] S_ISCAN = 4'd4;
  localparam logic [3:0] S_MERGE = 4'd5;
  localparam logic [3:0] S_FRD   = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  typedef struct packed {
    logic [ASW-1:0] size;
    logic [AW-1:0]  start;
  } arec_t;

  logic [3:0]       state;
  logic             op_q;
  logic [RW-1:0]    req_q;
  logic [AW-1:0]    addr_q;
  logic [AW-1:0]    res_q;
  logic [STW-1:0]   st_q;
  logic [LW-1:0]    chunk_limit;
  logic [AI_W-1:0]  j;
  logic [AI_W-1:0]  slot;
  logic [AI_W-1:0]  hit_j;
  logic [FC_W-1:0]  i;
  logic [FC_W-1:0]  p;
  logic [FC_W-1:0]  fcount;
  logic [CU_W-1:0]  chunks_used;
  logic             ex_found;
  logic             bs_found;
  logic [FI_W-1:0]  ex_idx;
  logic [FI_W-1:0]  bs_idx;
  logic [SW-1:0]    bs_size;
  logic             grown;
  logic [AW-1:0]    ins_start;
  logic [SW-1:0]    ins_size;
  logic [MAX_ALLOC_ENTRIES-1:0] avalid;
  arec_t            amem [MAX_ALLOC_ENTRIES];
  arec_t            rd_q;
  logic             mem_we;
  arec_t            mem_wdata;
  logic [15:0]      m_data_q;
  logic [2:0]       m_user_q;

  bfca_pkg::entry_t    cq  [MAX_FREE_ENTRIES];
  bfca_pkg::cell_cmd_t cmd [MAX_FREE_ENTRIES];

  // Free-list command decode.
  logic             do_wr;
  logic             do_shl;
  logic             do_shr;
  logic [FC_W-1:0]  wr_idx;
  logic [FC_W-1:0]  sh_pos;
  bfca_pkg::entry_t wr_data;

  // Views of the cells that the current step looks at.
  bfca_pkg::entry_t ent_i;
  bfca_pkg::entry_t ent_k;
  bfca_pkg::entry_t ent_p;
  bfca_pkg::entry_t ent_pm1;
  logic [FI_W-1:0]  k;
  logic [FC_W-1:0]  pm1;
  logic [WW-1:0]    k_size_w;
  logic             split;
  logic [SW-1:0]    rem;
  logic [AW-1:0]    user_split;
  logic [AW-1:0]    user_whole;
  logic             jl;
  logic             jr;
  logic             room;
  logic [6:0]       lim;
  logic             pay_big;

  assign k        = ex_found ? ex_idx : bs_idx;
  assign pm1      = p - FC_W'(1);
  assign ent_i    = cq[i[FI_W-1:0]];
  assign ent_k    = cq[k];
  assign ent_p    = cq[p[FI_W-1:0]];
  assign ent_pm1  = cq[pm1[FI_W-1:0]];
  assign k_size_w = WW'(ent_k.size);
  assign split    = k_size_w >= (WW'(req_q) + HDR + WW'(1));
  assign rem      = SW'(k_size_w - WW'(req_q) - HDR);
  assign user_split = AW'(WW'(ent_k.start) + HDR + WW'(rem) + HDR);
  assign user_whole = AW'(WW'(ent_k.start) + HDR);
  assign jl = (p != '0) &&
              (WW'(ent_pm1.start) + HDR + WW'(ent_pm1.size) == WW'(ins_start));
  assign jr = (p < fcount) &&
              (WW'(ins_start) + HDR + WW'(ins_size) == WW'(ent_p.start));
  assign room = fcount < FC_W'(MAX_FREE_ENTRIES);
  assign lim  = (7'(chunk_limit) > 7'(MAX_CHUNKS)) ? 7'(MAX_CHUNKS) : 7'(chunk_limit);
  assign pay_big = 32'(s_tdata[15:0]) > 32'(PAYLOAD);

  always_comb begin
    do_wr   = 1'b0;
    do_shl  = 1'b0;
    do_shr  = 1'b0;
    wr_idx  = '0;
    sh_pos  = '0;
    wr_data = '0;
    mem_we  = 1'b0;
    mem_wdata = '0;
    case (state)
      S_TAKE: begin
        mem_we = 1'b1;
        if (split) begin
          do_wr   = 1'b1;
          wr_idx  = FC_W'(k);
          wr_data = '{start: ent_k.start, size: rem};
          mem_wdata = '{size: ASW'(req_q), start: user_split};
        end else begin
          do_shl  = 1'b1;
          sh_pos  = FC_W'(k);
          mem_wdata = '{size: ASW'(ent_k.size), start: user_whole};
        end
      end
      S_MERGE: begin
        if (jl && jr) begin
          do_wr   = 1'b1;
          wr_idx  = pm1;
          wr_data = '{start: ent_pm1.start,
                      size: SW'(WW'(ent_pm1.size) + HDR + WW'(ins_size) + HDR
                                + WW'(ent_p.size))};
          do_shl  = 1'b1;
          sh_pos  = p;
        end else if (jl) begin
          do_wr   = 1'b1;
          wr_idx  = pm1;
          wr_data = '{start: ent_pm1.start,
                      size: SW'(WW'(ent_pm1.size) + HDR + WW'(ins_size))};
        end else if (jr) begin
          do_wr   = 1'b1;
          wr_idx  = p;
          wr_data = '{start: ins_start,
                      size: SW'(WW'(ent_p.size) + HDR + WW'(ins_size))};
        end else if (room) begin
          do_shr  = 1'b1;
          sh_pos  = p;
          do_wr   = 1'b1;
          wr_idx  = p;
          wr_data = '{start: ins_start, size: ins_size};
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < MAX_FREE_ENTRIES; g++) begin : g_cell
    bfca_pkg::entry_t left_d;
    bfca_pkg::entry_t right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cq[g-1];
    end
    if (g == MAX_FREE_ENTRIES - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cq[g+1];
    end
    assign cmd[g].wr   = do_wr && (wr_idx == FC_W'(g));
    assign cmd[g].shl  = do_shl && (FC_W'(g) >= sh_pos);
    assign cmd[g].shr  = do_shr && (FC_W'(g) > sh_pos);
    assign cmd[g].data = wr_data;

    bfca_cell u_cell (
      .clk   (clk),
      .cmd   (cmd[g]),
      .left  (left_d),
      .right (right_d),
      .q     (cq[g])
    );
  end

  // Allocation table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      amem[slot] <= mem_wdata;
    end
    rd_q <= amem[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fcount      <= '0;
      chunks_used <= '0;
      avalid      <= '0;
      chunk_limit <= LW'(16);
      m_tvalid    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == bfca_pkg::REG_CHUNK_LIMIT) begin
        chunk_limit <= pwdata[LW-1:0];
      end
      // In S_DONE the output register is reloaded below instead.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q   <= s_tuser[0];
            req_q  <= s_tdata[15:0];
            addr_q <= s_tdata[30:16];
            res_q  <= '0;
            j      <= '0;
            if (s_tuser[0] == bfca_pkg::OP_FREE) begin
              state <= S_FRD;
            end else if (pay_big) begin
              st_q  <= bfca_pkg::ST_LARGE;
              state <= S_DONE;
            end else if (s_tdata[15:0] == '0) begin
              st_q  <= bfca_pkg::ST_ZERO;
              state <= S_DONE;
            end else begin
              state <= S_SLOT;
            end
          end
        end
        S_SLOT: begin
          if (!avalid[j]) begin
            slot     <= j;
            i        <= '0;
            ex_found <= 1'b0;
            bs_found <= 1'b0;
            grown    <= 1'b0;
            state    <= S_FIT;
          end else if (32'(j) == MAX_ALLOC_ENTRIES - 1) begin
            st_q  <= bfca_pkg::ST_FULL;
            state <= S_DONE;
          end else begin
            j <= j + AI_W'(1);
          end
        end
        S_FIT: begin
          if (i < fcount) begin
            if (!ex_found && RW'(ent_i.size) == req_q) begin
              ex_found <= 1'b1;
              ex_idx   <= i[FI_W-1:0];
            end
            if (RW'(ent_i.size) > req_q && (!bs_found || ent_i.size < bs_size)) begin
              bs_found <= 1'b1;
              bs_idx   <= i[FI_W-1:0];
              bs_size  <= ent_i.size;
            end
            i <= i + FC_W'(1);
          end else if (ex_found || bs_found) begin
            state <= S_TAKE;
          end else if (grown || 7'(chunks_used) >= lim) begin
            st_q  <= bfca_pkg::ST_OOM;
            state <= S_DONE;
          end else begin
            ins_start <= AW'(32'(chunks_used) * CHUNK_BYTES);
            ins_size  <= SW'(PAYLOAD);
            p         <= '0;
            state     <= S_ISCAN;
          end
        end
        S_TAKE: begin
          if (!split) begin
            fcount <= fcount - FC_W'(1);
          end
          avalid[slot] <= 1'b1;
          res_q <= split ? user_split : user_whole;
          st_q  <= bfca_pkg::ST_OK;
          state <= S_DONE;
        end
        S_ISCAN: begin
          if (p < fcount && ent_p.start < ins_start) begin
            p <= p + FC_W'(1);
          end else begin
            state <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (jl && jr) begin
            fcount <= fcount - FC_W'(1);
          end else if (!jl && !jr && room) begin
            fcount <= fcount + FC_W'(1);
          end
          if (jl || jr || room) begin
            if (op_q == bfca_pkg::OP_FREE) begin
              avalid[hit_j] <= 1'b0;
              st_q  <= bfca_pkg::ST_OK;
              state <= S_DONE;
            end else begin
              chunks_used <= chunks_used + CU_W'(1);
              grown    <= 1'b1;
              i        <= '0;
              ex_found <= 1'b0;
              bs_found <= 1'b0;
              state    <= S_FIT;
            end
          end else begin
            st_q  <= bfca_pkg::ST_FULL;
            state <= S_DONE;
          end
        end
        S_FRD: begin
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (avalid[j] && rd_q.start == addr_q) begin
            if (WW'(addr_q) < HDR) begin
              st_q  <= bfca_pkg::ST_UNKNOWN;
              state <= S_DONE;
            end else begin
              hit_j     <= j;
              ins_start <= AW'(WW'(addr_q) - HDR);
              ins_size  <= SW'(rd_q.size);
              p         <= '0;
              state     <= S_ISCAN;
            end
          end else if (32'(j) == MAX_ALLOC_ENTRIES - 1) begin
            st_q  <= bfca_pkg::ST_UNKNOWN;
            state <= S_DONE;
          end else begin
            j     <= j + AI_W'(1);
            state <= S_FRD;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_data_q <= {1'b0, res_q};
            m_user_q <= st_q;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = m_data_q;
  assign m_tuser  = m_user_q;
  assign prdata   = (paddr == bfca_pkg::REG_CHUNK_LIMIT) ?
                    {{(32-LW){1'b0}}, chunk_limit} : 32'd0;
  assign pready   = 1'b1;

endmodule
`default_nettype wire
